@@ rtl/core/dq_pkg.sv @@
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] NONE_VAL = -32'sd1;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cell control for one step
  typedef struct packed {
    logic shift_right;  // push front: take the left neighbour
    logic shift_left;   // pop front: take the right neighbour
    logic load;         // push rear: take the pushed value
  } cell_ctrl_t;

endpackage

@@ rtl/core/dq_chan_if.sv @@
interface dq_req_if
  import dq_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  data_t             value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dq_rsp_if
  import dq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  data_t              front_value;
  data_t              rear_value;
  logic [COUNT_W-1:0] count;
  logic               empty_res;
  logic               full_res;

  modport source (output valid, output status, output front_value, output rear_value,
                  output count, output empty_res, output full_res, input ready);
  modport sink   (input valid, input status, input front_value, input rear_value,
                  input count, input empty_res, input full_res, output ready);
endinterface

@@ rtl/core/dq_cell.sv @@
module dq_cell
  import dq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  data_t      left_data,
  input  data_t      right_data,
  input  data_t      push_value,
  output data_t      data
);

  always_ff @(posedge clk) begin
    if (ctrl.shift_right) begin
      data <= left_data;
    end else if (ctrl.shift_left) begin
      data <= right_data;
    end else if (ctrl.load) begin
      data <= push_value;
    end
  end

endmodule

@@ rtl/core/circular_deque.sv @@
// channel  dir  beat contents
// -------  ---  ---------------------------------------------------------------
// req      in   cmd, value
// rsp      out  status, front_value, rear_value, count, empty_res, full_res
//
// One command per cycle while no result stalls: the row of cells shifts or
// loads on accept, and the result is held in an output register until taken.
// Cell 0 is the front; live entries sit in cells 0 to count-1.
// Reset clears the count and the result register; cell contents are not reset.
// A stalled result holds req.ready low, so the cells stay put underneath it.
module circular_deque
  import dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dq_req_if.sink      req,
  dq_rsp_if.source    rsp
);

  logic [COUNT_W-1:0] held;
  logic [COUNT_W-1:0] held_next;
  logic               out_valid;
  logic [STAT_W-1:0]  status;
  logic [STAT_W-1:0]  status_next;
  logic               accept;
  logic               is_empty;
  logic               is_full;
  logic               do_push_front;
  logic               do_push_rear;
  logic               do_pop_front;
  logic [IDX_W-1:0]   rear_idx;
  data_t              cell_data [DEPTH];
  cell_ctrl_t         cell_ctrl [DEPTH];

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_empty  = (held == '0);
  assign is_full   = (held == COUNT_W'(DEPTH));

  always_comb begin
    do_push_front = 1'b0;
    do_push_rear  = 1'b0;
    do_pop_front  = 1'b0;
    status_next   = ST_DONE;
    held_next     = held;
    case (req.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          held_next = held + COUNT_W'(1);
          // into an empty row both pushes land in cell 0
          if (req.cmd == CMD_PUSH_FRONT) begin
            do_push_front = 1'b1;
          end else begin
            do_push_rear = 1'b1;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          held_next = held - COUNT_W'(1);
          // pop rear only shortens the row
          if (req.cmd == CMD_POP_FRONT) begin
            do_pop_front = 1'b1;
          end
        end
      end
      CMD_PEEK: begin
        status_next = ST_DONE;
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_data;
    data_t right_data;

    if (i == 0) begin : g_first
      assign left_data = req.value;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    assign cell_ctrl[i].shift_right = accept && do_push_front;
    assign cell_ctrl[i].shift_left  = accept && do_pop_front;
    assign cell_ctrl[i].load        = accept && do_push_rear && (held == COUNT_W'(i));

    dq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .left_data  (left_data),
      .right_data (right_data),
      .push_value (req.value),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      out_valid <= 1'b0;
      status    <= ST_DONE;
    end else begin
      if (accept) begin
        held      <= held_next;
        status    <= status_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // rear sits in the last live cell
  assign rear_idx = IDX_W'(held - COUNT_W'(1));

  assign rsp.valid       = out_valid;
  assign rsp.status      = status;
  assign rsp.count       = held;
  assign rsp.empty_res   = is_empty;
  assign rsp.full_res    = is_full;
  assign rsp.front_value = is_empty ? NONE_VAL : cell_data[0];
  assign rsp.rear_value  = is_empty ? NONE_VAL : cell_data[rear_idx];

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= COUNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> rsp.full_res)
    else $error("push rejected while not full");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (do_push_front || do_push_rear)) |=> (held == $past(held) + COUNT_W'(1)))
    else $error("accepted push did not grow the count");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> ($stable(held) && $stable(rsp.front_value)))
    else $error("state moved under a stalled result");

endmodule

@@ dv/tb_circular_deque.sv @@
`timescale 1ns / 1ps

module tb_circular_deque;
  import dq_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1800;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_MAX     = 10;
  localparam int HOLD_EVERY     = 700;

  // codes above peek are spare and behave as peek
  localparam logic [CMD_W-1:0] CMD_SPARE_TOP = 3'd7;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    data_t              front_value;
    data_t              rear_value;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               full_res;
  } result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    data_t            value;
    int               reps;
    bit               typed;
    result_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  dq_req_if req ();
  dq_rsp_if rsp ();

  circular_deque dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mirror of the deque contents
  data_t mirror_cells [DEPTH];
  int    mirror_head = 0;
  int    mirror_tail = 0;
  int    mirror_held = 0;

  result_t pending_results [$];
  int      bad_beats    = 0;
  int      results_seen = 0;
  int      idle_cycles  = 0;
  row_t    directed [14];

  function automatic result_t deque_apply(input logic [CMD_W-1:0] c, input data_t v);
    result_t r;
    r        = '0;
    r.status = ST_DONE;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (mirror_held == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (mirror_held == 0) begin
            mirror_head     = 0;
            mirror_tail     = 0;
            mirror_cells[0] = v;
          end else if (c == CMD_PUSH_FRONT) begin
            mirror_head = (mirror_head == 0) ? DEPTH - 1 : mirror_head - 1;
            mirror_cells[mirror_head] = v;
          end else begin
            mirror_tail = (mirror_tail == DEPTH - 1) ? 0 : mirror_tail + 1;
            mirror_cells[mirror_tail] = v;
          end
          mirror_held++;
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (mirror_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          mirror_held--;
          if (mirror_held == 0) begin
            mirror_head = 0;
            mirror_tail = 0;
          end else if (c == CMD_POP_FRONT) begin
            mirror_head = (mirror_head == DEPTH - 1) ? 0 : mirror_head + 1;
          end else begin
            mirror_tail = (mirror_tail == 0) ? DEPTH - 1 : mirror_tail - 1;
          end
        end
      end
      default: ;
    endcase
    r.front_value = (mirror_held == 0) ? NONE_VAL : mirror_cells[mirror_head];
    r.rear_value  = (mirror_held == 0) ? NONE_VAL : mirror_cells[mirror_tail];
    r.count       = COUNT_W'(mirror_held);
    r.empty_res   = (mirror_held == 0);
    r.full_res    = (mirror_held == DEPTH);
    return r;
  endfunction

  function automatic result_t shape(input logic [STAT_W-1:0] st, input data_t f,
                                    input data_t r, input int n);
    result_t s;
    s.status      = st;
    s.front_value = f;
    s.rear_value  = r;
    s.count       = COUNT_W'(n);
    s.empty_res   = (n == 0);
    s.full_res    = (n == DEPTH);
    return s;
  endfunction

  // mostly back to back, sometimes a short gap, now and then a long stretch
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(input logic [CMD_W-1:0] c, input data_t v, input bit typed,
                      input result_t want, input int gap);
    result_t predicted;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = deque_apply(c, v);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int               burst;
    int               push_share;
    int               roll;
    bit               calm;
    logic [CMD_W-1:0] c;
    data_t            v;

    rst       <= 1'b1;
    req.valid <= 1'b0;
    req.cmd   <= CMD_PEEK;
    req.value <= '0;

    directed[0]  = '{CMD_POP_FRONT, '0, 1, 1'b1, shape(ST_EMPTY, NONE_VAL, NONE_VAL, 0)};
    directed[1]  = '{CMD_POP_REAR, NONE_VAL, 1, 1'b1, shape(ST_EMPTY, NONE_VAL, NONE_VAL, 0)};
    directed[2]  = '{CMD_SPARE_TOP, NONE_VAL, 1, 1'b1, shape(ST_DONE, NONE_VAL, NONE_VAL, 0)};
    directed[3]  = '{CMD_PUSH_REAR, DATA_MAX, 1, 1'b1, shape(ST_DONE, DATA_MAX, DATA_MAX, 1)};
    directed[4]  = '{CMD_PUSH_FRONT, DATA_MIN, 1, 1'b1, shape(ST_DONE, DATA_MIN, DATA_MAX, 2)};
    directed[5]  = '{CMD_POP_REAR, '0, 1, 1'b0, '0};
    // last entry out: both ends read as empty
    directed[6]  = '{CMD_POP_FRONT, '0, 1, 1'b1, shape(ST_DONE, NONE_VAL, NONE_VAL, 0)};
    directed[7]  = '{CMD_PUSH_FRONT, 32'sh5555_5555, 1, 1'b1,
                     shape(ST_DONE, 32'sh5555_5555, 32'sh5555_5555, 1)};
    // front pointer wraps below zero
    directed[8]  = '{CMD_PUSH_FRONT, '0, 1, 1'b0, '0};
    directed[9]  = '{CMD_PUSH_REAR, 32'shAAAA_AAAA, DEPTH - 2, 1'b0, '0};
    directed[10] = '{CMD_PUSH_REAR, 32'sd1, 1, 1'b1,
                     shape(ST_FULL, '0, 32'shAAAA_AAAA, DEPTH)};
    directed[11] = '{CMD_PUSH_FRONT, 32'sd2, 1, 1'b1,
                     shape(ST_FULL, '0, 32'shAAAA_AAAA, DEPTH)};
    directed[12] = '{CMD_PEEK, DATA_MAX, 1, 1'b0, '0};
    directed[13] = '{CMD_POP_FRONT, '0, 1, 1'b0, '0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      repeat (directed[i].reps)
        send(directed[i].cmd, directed[i].value, directed[i].typed, directed[i].want,
             pick_gap());
    end

    // bursts lean towards pushes or pops so both full and empty are visited often
    for (int sent = 0; sent < RANDOM_ITEMS; ) begin
      burst = $urandom_range(4, 40);
      roll  = $urandom_range(0, 3);
      push_share = (roll == 0) ? 80 : (roll == 1) ? 20 : 50;
      calm  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 6)
          c = CMD_W'($urandom_range(CMD_PEEK, CMD_SPARE_TOP));
        else if ($urandom_range(0, 99) < push_share)
          c = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        else
          c = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
        v = $urandom;
        send(c, v, 1'b0, '0, calm ? 0 : pick_gap());
        sent++;
        if (sent == RANDOM_ITEMS / 2)
          wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_beats == 0) begin
      $display("tb_circular_deque: clean");
    end else begin
      $display("tb_circular_deque: errors");
    end
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    int calm_left;
    int hold_mark;
    bit calm;
    stall_left = 0;
    calm_left  = 0;
    hold_mark  = 300;
    calm       = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      // hold off long enough for the block to back up onto its input
      if (results_seen >= hold_mark) begin
        hold_mark += HOLD_EVERY;
        rsp.ready <= 1'b0;
        repeat ($urandom_range(60, 90)) @(posedge clk);
      end
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 2) == 0);
        calm_left = $urandom_range(16, 80);
      end
      calm_left--;
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status      = rsp.status;
      got.front_value = rsp.front_value;
      got.rear_value  = rsp.rear_value;
      got.count       = rsp.count;
      got.empty_res   = rsp.empty_res;
      got.full_res    = rsp.full_res;
      results_seen++;
      if (pending_results.size() == 0) begin
        bad_beats++;
        if (bad_beats <= REPORT_MAX)
          $display("[%0t] result beat with nothing outstanding", $time);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (got !== want) begin
          bad_beats++;
          if (bad_beats <= REPORT_MAX) begin
            $display("[%0t] result mismatch: got  st=%0d front=%0d rear=%0d n=%0d e=%0b f=%0b",
                     $time, got.status, got.front_value, got.rear_value, got.count,
                     got.empty_res, got.full_res);
            $display("[%0t] result mismatch: want st=%0d front=%0d rear=%0d n=%0d e=%0b f=%0b",
                     $time, want.status, want.front_value, want.rear_value, want.count,
                     want.empty_res, want.full_res);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_circular_deque: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ filelist.f @@
rtl/core/dq_pkg.sv
rtl/core/dq_chan_if.sv
rtl/core/dq_cell.sv
rtl/core/circular_deque.sv
dv/tb_circular_deque.sv
